// ----- rtl/core/drt_pkg.sv -----
// shared types, constants and helpers of the dirty row tracker
`default_nettype none

package drt_pkg;

   // default frame height in rows
   localparam int MAX_ROWS_DEF = 4096;

   // dirty bits are stored 32 rows to a memory word
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;
   localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

   // field widths
   localparam int OPERATION_W   = 1;
   localparam int FIRST_ROW_W   = 12;
   localparam int END_ROW_W     = 13;
   localparam int RUN_ROW_W     = 12;
   localparam int RUN_ROWS_W    = 13;
   localparam int WORD_OFFSET_W = 26;
   localparam int WORD_COUNT_W  = 27;
   localparam int ROW_COUNT_W   = 13;
   localparam int WPR_W         = 15;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 15;

   // reset values of the registers
   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 13'd4096;

   // operation codes
   localparam logic [OPERATION_W-1:0] OP_MARK  = 1'b0;
   localparam logic [OPERATION_W-1:0] OP_FLUSH = 1'b1;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHADOW_ENABLED = 2'd0,
      CSR_ROW_COUNT      = 2'd1,
      CSR_WORDS_PER_ROW  = 2'd2
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic clr;
      logic acc_mark;
      logic acc_flush;
      logic rd;
      logic rd_next;
      logic mk_wr;
      logic scan;
      logic run;
      logic len;
      logic load_run;
      logic load_done;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic enabled;
      logic is_flush;
      logic mk_ok;
      logic fl_skip;
      logic fl_live;
      logic clr_last;
      logic last_word;
      logic scan_hit;
      logic run_cont;
   } dp_sts_type;

   // index of the lowest set bit, WORD_BITS when none is set
   function automatic logic [BIT_W:0] first_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W:0] r;
      r = (BIT_W+1)'(WORD_BITS);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = (BIT_W+1)'(i);
         end
      end
      return r;
   endfunction

   // ones from bit lo up to bit hi, both included
   function automatic logic [WORD_BITS-1:0] span_mask(input logic [BIT_W-1:0] lo,
                                                      input logic [BIT_W-1:0] hi);
      logic [BIT_W-1:0] top;
      top = BIT_W'(WORD_BITS - 1) - hi;
      return (WORD_ONES << lo) & (WORD_ONES >> top);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/drt_channels.sv -----
// request and response channel interfaces of the dirty row tracker
`default_nettype none

interface drt_req_intf;
   logic                                 valid;
   logic                                 ready;
   logic [drt_pkg::OPERATION_W-1:0]      operation;
   logic [drt_pkg::FIRST_ROW_W-1:0]      first_row;
   logic [drt_pkg::END_ROW_W-1:0]        end_row;

   modport source (output valid, output operation, output first_row, output end_row,
                   input ready);
   modport sink   (input valid, input operation, input first_row, input end_row,
                   output ready);
endinterface

interface drt_rsp_intf;
   logic                                 valid;
   logic                                 ready;
   logic [drt_pkg::RUN_ROW_W-1:0]        run_row;
   logic [drt_pkg::RUN_ROWS_W-1:0]       run_rows;
   logic [drt_pkg::WORD_OFFSET_W-1:0]    word_offset;
   logic [drt_pkg::WORD_COUNT_W-1:0]     word_count;
   logic                                 done_res;

   modport source (output valid, output run_row, output run_rows, output word_offset,
                   output word_count, output done_res, input ready);
   modport sink   (input valid, input run_row, input run_rows, input word_offset,
                   input word_count, input done_res, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/drt_dp.sv -----
// datapath of the dirty row tracker: dirty bit memory, envelope, cursors, result
`default_nettype none

module drt_dp #(
   parameter int MAX_ROWS = drt_pkg::MAX_ROWS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire drt_pkg::dp_cmd_type                 cmd,
   output drt_pkg::dp_sts_type                      sts,
   input  wire logic [drt_pkg::OPERATION_W-1:0]     req_operation,
   input  wire logic [drt_pkg::FIRST_ROW_W-1:0]     req_first_row,
   input  wire logic [drt_pkg::END_ROW_W-1:0]       req_end_row,
   input  wire logic                                shadow_enabled,
   input  wire logic [drt_pkg::ROW_COUNT_W-1:0]     row_count,
   input  wire logic [drt_pkg::WPR_W-1:0]           words_per_row,
   output logic [drt_pkg::RUN_ROW_W-1:0]            rsp_run_row,
   output logic [drt_pkg::RUN_ROWS_W-1:0]           rsp_run_rows,
   output logic [drt_pkg::WORD_OFFSET_W-1:0]        rsp_word_offset,
   output logic [drt_pkg::WORD_COUNT_W-1:0]         rsp_word_count,
   output logic                                     rsp_done_res
);
   import drt_pkg::*;

   localparam int DEPTH  = (MAX_ROWS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EX_W   = ADDR_W + BIT_W + 1;
   localparam int CMP_W  = (EX_W > ROW_COUNT_W) ? EX_W : ROW_COUNT_W;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_ff;

   logic [EX_W-1:0]   y_ff, y_in;
   logic [EX_W-1:0]   lim_ff, lim_in;
   logic [EX_W-1:0]   start_ff, start_in;
   logic [EX_W-1:0]   len_ff, len_in;
   logic [EX_W-1:0]   env_low_ff, env_low_in;
   logic [EX_W-1:0]   env_high_ff, env_high_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   logic [RUN_ROW_W-1:0]     run_row_ff, run_row_in;
   logic [RUN_ROWS_W-1:0]    run_rows_ff, run_rows_in;
   logic [WORD_OFFSET_W-1:0] word_offset_ff, word_offset_in;
   logic [WORD_COUNT_W-1:0]  word_count_ff, word_count_in;
   logic                     done_res_ff, done_res_in;

   logic [CMP_W-1:0] rows_c, first_c, end_raw, end_c, last_c;
   logic [CMP_W-1:0] env_low_c, env_high_c, hi_c;

   logic [ADDR_W-1:0]    y_word, lim_word, rd_addr, wr_addr;
   logic [BIT_W-1:0]     y_bit, lim_bit, up_bit;
   logic                 last_word;
   logic [EX_W-1:0]      word_base, next_row, scan_row, run_end_row;
   logic [WORD_BITS-1:0] scan_m, run_z, run_clear, wr_data;
   logic [BIT_W:0]       scan_pos, run_e;
   logic                 wr_en, rd_en;

   logic [EX_W+WPR_W-1:0] off_prod, cnt_prod;

   // frame size and mark range, clamped
   always_comb begin
      rows_c     = (CMP_W'(row_count) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS)
                                                          : CMP_W'(row_count);
      first_c    = CMP_W'(req_first_row);
      end_raw    = CMP_W'(req_end_row);
      end_c      = (end_raw > rows_c) ? rows_c : end_raw;
      last_c     = end_c - CMP_W'(1);
      env_low_c  = CMP_W'(env_low_ff);
      env_high_c = CMP_W'(env_high_ff);
      hi_c       = (env_high_c >= rows_c) ? (rows_c - CMP_W'(1)) : env_high_c;
   end

   // word and bit of the cursor and of the limit row
   always_comb begin
      y_word      = y_ff[EX_W-2:BIT_W];
      y_bit       = y_ff[BIT_W-1:0];
      lim_word    = lim_ff[EX_W-2:BIT_W];
      lim_bit     = lim_ff[BIT_W-1:0];
      last_word   = (y_word == lim_word);
      up_bit      = last_word ? lim_bit : BIT_W'(WORD_BITS - 1);
      word_base   = {1'b0, y_word, {BIT_W{1'b0}}};
      next_row    = word_base + EX_W'(WORD_BITS);
      scan_m      = rd_ff & span_mask(y_bit, up_bit);
      scan_pos    = first_set(scan_m);
      scan_row    = word_base + EX_W'(scan_pos);
      run_z       = (~rd_ff | ~span_mask('0, up_bit)) & (WORD_ONES << y_bit);
      run_e       = first_set(run_z);
      run_clear   = (WORD_ONES << y_bit) & ~(WORD_ONES << run_e);
      run_end_row = word_base + EX_W'(run_e);
   end

   // memory port selection
   always_comb begin
      rd_en   = cmd.rd | cmd.rd_next;
      rd_addr = cmd.rd_next ? (y_word + ADDR_W'(1)) : y_word;
      wr_en   = cmd.clr | cmd.mk_wr | cmd.run;
      wr_addr = y_word;
      wr_data = rd_ff & ~run_clear;
      if (cmd.clr) begin
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (cmd.mk_wr) begin
         wr_data = rd_ff | span_mask(y_bit, up_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign off_prod = start_ff * words_per_row;
   assign cnt_prod = len_ff * words_per_row;

   // next values of cursors, envelope and result
   always_comb begin
      y_in           = y_ff;
      lim_in         = lim_ff;
      start_in       = start_ff;
      len_in         = len_ff;
      env_low_in     = env_low_ff;
      env_high_in    = env_high_ff;
      clr_in         = clr_ff;
      run_row_in     = run_row_ff;
      run_rows_in    = run_rows_ff;
      word_offset_in = word_offset_ff;
      word_count_in  = word_count_ff;
      done_res_in    = done_res_ff;
      if (cmd.clr) begin
         clr_in = clr_ff + ADDR_W'(1);
      end
      if (cmd.acc_mark) begin
         y_in   = EX_W'(first_c);
         lim_in = EX_W'(last_c);
         if (first_c < env_low_c) begin
            env_low_in = EX_W'(first_c);
         end
         if (last_c > env_high_c) begin
            env_high_in = EX_W'(last_c);
         end
      end
      if (cmd.acc_flush) begin
         y_in   = env_low_ff;
         lim_in = EX_W'(hi_c);
      end
      if (cmd.mk_wr) begin
         y_in = next_row;
      end
      if (cmd.scan) begin
         y_in     = (scan_m != '0) ? scan_row : next_row;
         start_in = scan_row;
      end
      if (cmd.run) begin
         y_in = sts.run_cont ? next_row : run_end_row;
      end
      if (cmd.len) begin
         len_in     = y_ff - start_ff;
         env_low_in = y_ff;
      end
      if (cmd.load_run) begin
         run_row_in     = RUN_ROW_W'(start_ff);
         run_rows_in    = RUN_ROWS_W'(len_ff);
         word_offset_in = WORD_OFFSET_W'(off_prod);
         word_count_in  = WORD_COUNT_W'(cnt_prod);
         done_res_in    = 1'b0;
      end
      if (cmd.load_done) begin
         env_low_in     = EX_W'(MAX_ROWS);
         env_high_in    = '0;
         run_row_in     = '0;
         run_rows_in    = '0;
         word_offset_in = '0;
         word_count_in  = '0;
         done_res_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_low_ff  <= EX_W'(MAX_ROWS);
         env_high_ff <= '0;
         clr_ff      <= '0;
      end else begin
         env_low_ff  <= env_low_in;
         env_high_ff <= env_high_in;
         clr_ff      <= clr_in;
      end
      y_ff           <= y_in;
      lim_ff         <= lim_in;
      start_ff       <= start_in;
      len_ff         <= len_in;
      run_row_ff     <= run_row_in;
      run_rows_ff    <= run_rows_in;
      word_offset_ff <= word_offset_in;
      word_count_ff  <= word_count_in;
      done_res_ff    <= done_res_in;
   end

   always_comb begin
      sts.enabled   = shadow_enabled;
      sts.is_flush  = (req_operation == OP_FLUSH);
      sts.mk_ok     = (first_c < rows_c) && (end_c > first_c);
      sts.fl_skip   = (words_per_row == '0);
      sts.fl_live   = (env_low_ff <= env_high_ff) && (rows_c != '0) && (env_low_c <= hi_c);
      sts.clr_last  = (clr_ff == ADDR_W'(DEPTH - 1));
      sts.last_word = last_word;
      sts.scan_hit  = (scan_m != '0);
      sts.run_cont  = (run_e == (BIT_W+1)'(WORD_BITS)) && !last_word;
   end

   assign rsp_run_row     = run_row_ff;
   assign rsp_run_rows    = run_rows_ff;
   assign rsp_word_offset = word_offset_ff;
   assign rsp_word_count  = word_count_ff;
   assign rsp_done_res    = done_res_ff;

endmodule

`default_nettype wire

// ----- rtl/core/drt_ctrl.sv -----
// controller of the dirty row tracker: sequences clearing, marks and flushes
`default_nettype none

module drt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire drt_pkg::dp_sts_type  sts,
   output drt_pkg::dp_cmd_type       cmd
);
   import drt_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MK_RD,
      ST_MK_WR,
      ST_FL_RD,
      ST_FL_SCAN,
      ST_FL_RUN,
      ST_FL_LEN,
      ST_FL_OUT,
      ST_FL_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && sts.enabled) begin
               if (!sts.is_flush) begin
                  if (sts.mk_ok) begin
                     cmd.acc_mark = 1'b1;
                     state_in     = ST_MK_RD;
                  end
               end else if (!sts.fl_skip) begin
                  if (sts.fl_live) begin
                     cmd.acc_flush = 1'b1;
                     state_in      = ST_FL_RD;
                  end else begin
                     state_in = ST_FL_DONE;
                  end
               end
            end
         end
         ST_MK_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_MK_WR;
         end
         ST_MK_WR: begin
            cmd.mk_wr = 1'b1;
            if (sts.last_word) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         ST_FL_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_FL_SCAN;
         end
         ST_FL_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_hit) begin
               state_in = ST_FL_RUN;
            end else if (sts.last_word) begin
               state_in = ST_FL_DONE;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         ST_FL_RUN: begin
            cmd.run = 1'b1;
            if (sts.run_cont) begin
               cmd.rd_next = 1'b1;
            end else begin
               state_in = ST_FL_LEN;
            end
         end
         ST_FL_LEN: begin
            cmd.len  = 1'b1;
            state_in = ST_FL_OUT;
         end
         ST_FL_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_run = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FL_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_done = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/core/dirty_row_tracker_flush.sv -----
// top level of the dirty row tracker: config registers, controller and datapath
// mark: reads the first 32-row word, then writes each word spanned; ignored beats are dropped
// flush: a read, a scan step per word scanned, a run step per word the run covers (the hit
//   word counting in both), length and result; done skips the scan on a clean envelope
// one item at a time, one memory word per cycle; a held result beat stalls the next flush
// reset: synchronous; a clearing pass over every memory word takes no beats, config writes ok
`default_nettype none

module dirty_row_tracker_flush #(
   parameter int MAX_ROWS = drt_pkg::MAX_ROWS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   drt_req_intf.sink                              req_chan,
   drt_rsp_intf.source                            rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [drt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [drt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import drt_pkg::*;

   // configuration registers
   logic                   shadow_enabled_ff, shadow_enabled_in;
   logic [ROW_COUNT_W-1:0] row_count_ff, row_count_in;
   logic [WPR_W-1:0]       words_per_row_ff, words_per_row_in;

   // controller and datapath handshake
   dp_cmd_type cmd;
   dp_sts_type sts;

   // register write decode; unknown indexes are dropped
   always_comb begin
      shadow_enabled_in = shadow_enabled_ff;
      row_count_in      = row_count_ff;
      words_per_row_in  = words_per_row_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SHADOW_ENABLED: shadow_enabled_in = csr_wdata[0];
            CSR_ROW_COUNT:      row_count_in      = ROW_COUNT_W'(csr_wdata);
            CSR_WORDS_PER_ROW:  words_per_row_in  = WPR_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_enabled_ff <= 1'b0;
         row_count_ff      <= ROW_COUNT_RST;
         words_per_row_ff  <= '0;
      end else begin
         shadow_enabled_ff <= shadow_enabled_in;
         row_count_ff      <= row_count_in;
         words_per_row_ff  <= words_per_row_in;
      end
   end

   // sequencer: clearing pass, mark word loop, flush scan and run loops
   drt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // dirty bit memory, envelope, cursors and the result register
   drt_dp #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_chan.operation),
      .req_first_row   (req_chan.first_row),
      .req_end_row     (req_chan.end_row),
      .shadow_enabled  (shadow_enabled_ff),
      .row_count       (row_count_ff),
      .words_per_row   (words_per_row_ff),
      .rsp_run_row     (rsp_chan.run_row),
      .rsp_run_rows    (rsp_chan.run_rows),
      .rsp_word_offset (rsp_chan.word_offset),
      .rsp_word_count  (rsp_chan.word_count),
      .rsp_done_res    (rsp_chan.done_res)
   );

endmodule

`default_nettype wire
